[rtl/bpas_pkg.sv]
// types and constants shared by the block padding add/strip modules
package bpas_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PEND,
      ST_BODY
   } state_type;

   typedef struct packed {
      logic shift;
      logic rotate;
   } chain_ctl_type;

   localparam logic [1:0] PAD_LEN   = 2'd0;
   localparam logic [1:0] PAD_ONE   = 2'd1;
   localparam logic [1:0] PAD_SPACE = 2'd2;
   localparam logic [1:0] PAD_ZERO  = 2'd3;

   localparam logic [7:0] BYTE_ONE   = 8'h80;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_ZERO  = 8'h00;

   localparam logic [1:0] REG_PAD_MODE    = 2'd0;
   localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
   localparam logic [1:0] REG_STRIP_MODE  = 2'd2;

   localparam logic [5:0] BLOCK_BYTES_RESET = 6'd16;

endpackage

[rtl/bpas_cell.sv]
// one byte cell of the block delay line
module bpas_cell (
   input  logic       clock,
   input  logic       shift,
   input  logic [7:0] data_in,
   output logic [7:0] data_out
);

   logic [7:0] data_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

[rtl/bpas_chain.sv]
// row of byte cells holding the last block, with an end tap and rotate path
module bpas_chain
   import bpas_pkg::*;
#(
   parameter int BLOCK_MAX = 32,
   localparam int IDXW = $clog2(BLOCK_MAX)
) (
   input  logic            clock,
   input  chain_ctl_type   chain_ctl,
   input  logic [7:0]      head_byte,
   input  logic [IDXW-1:0] tap_sel,
   output logic [7:0]      tap_byte
);

   logic [7:0] cell_d [BLOCK_MAX];
   logic [7:0] cell_q [BLOCK_MAX];

   assign cell_d[0] = chain_ctl.rotate ? tap_byte : head_byte;

   for (genvar g = 0; g < BLOCK_MAX; g++) begin : g_cell
      if (g > 0) begin : g_link
         assign cell_d[g] = cell_q[g-1];
      end
      bpas_cell u_cell (
         .clock    (clock),
         .shift    (chain_ctl.shift),
         .data_in  (cell_d[g]),
         .data_out (cell_q[g])
      );
   end

   assign tap_byte = cell_q[tap_sel];

endmodule

[rtl/bpas_ctrl.sv]
// message sequencer: block position, end scan, padding and output register
module bpas_ctrl
   import bpas_pkg::*;
#(
   parameter int BLOCK_MAX = 32,
   localparam int CNTW = $clog2(BLOCK_MAX + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [1:0]      pad_mode,
   input  logic            strip_mode,
   input  logic [CNTW-1:0] blk_b,
   input  logic            cfg_clear,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [7:0]      req_tdata,
   input  logic            req_tuser,
   input  logic            req_tlast,
   input  logic [7:0]      tap_byte,
   output chain_ctl_type   chain_ctl,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic            rsp_tuser,
   output logic            rsp_tlast
);

   state_type       state_ff, state_in;
   logic [CNTW-1:0] fill_ff, fill_in;
   logic            held_ff, held_in;
   logic [CNTW-1:0] lo_ff, lo_in;
   logic [CNTW-1:0] pos_ff, pos_in;
   logic [CNTW-1:0] keep_ff, keep_in;
   logic [7:0]      pend_ff, pend_in;
   logic            pend_vld_ff, pend_vld_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_has_ff, rsp_has_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            load_ok;
   logic            accept;
   logic [CNTW-1:0] fill_inc;
   logic            wrap;
   logic [CNTW-1:0] fill_nx;
   logic            rel_vld;
   logic [7:0]      rel_byte;
   logic            held_new;
   logic [CNTW:0]   scan_p;
   logic [CNTW:0]   pos_p1;
   logic            body_more;
   logic            body_end;
   logic            scan_end;
   logic [7:0]      pad_val;
   logic [7:0]      pad_ch;
   logic            emit;
   logic [7:0]      emit_byte;
   logic            emit_has;
   logic            emit_last;

   assign load_ok   = !rsp_valid_ff || rsp_tready;
   assign accept    = (state_ff == ST_IDLE) && req_tvalid && load_ok;
   assign fill_inc  = fill_ff + CNTW'(1);
   assign wrap      = req_tuser && (fill_inc >= blk_b);
   assign fill_nx   = !req_tuser ? fill_ff : (wrap ? '0 : fill_inc);
   assign rel_vld   = req_tuser && (!strip_mode || held_ff);
   assign rel_byte  = strip_mode ? tap_byte : req_tdata;
   assign held_new  = held_ff || (strip_mode && wrap);
   assign scan_p    = {1'b0, lo_ff} + {1'b0, pos_ff};
   assign pos_p1    = {1'b0, pos_ff} + (CNTW+1)'(1);
   assign body_more = pos_ff < keep_ff;
   assign body_end  = !body_more || (pos_p1 == {1'b0, keep_ff});
   assign scan_end  = pos_ff == (blk_b - CNTW'(1));
   assign pad_ch    = (pad_mode == PAD_SPACE) ? BYTE_SPACE : BYTE_ZERO;

   always_comb begin
      case (pad_mode)
         PAD_LEN:   pad_val = 8'(blk_b - lo_ff);
         PAD_ONE:   pad_val = (pos_ff == lo_ff) ? BYTE_ONE : BYTE_ZERO;
         PAD_SPACE: pad_val = BYTE_SPACE;
         default:   pad_val = BYTE_ZERO;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_tlast) begin
               if (!strip_mode) begin
                  state_in = rel_vld ? ST_PEND : ST_BODY;
               end else if (held_new) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_BODY;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = pend_vld_ff ? ST_PEND : ST_BODY;
            end
         end
         ST_PEND: begin
            if (load_ok) begin
               state_in = body_more ? ST_BODY : ST_IDLE;
            end
         end
         ST_BODY: begin
            if (load_ok && body_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of each state
   always_comb begin
      req_tready = (state_ff == ST_IDLE) && load_ok;
      chain_ctl  = '0;
      emit       = 1'b0;
      emit_byte  = BYTE_ZERO;
      emit_has   = 1'b0;
      emit_last  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               chain_ctl.shift = strip_mode && req_tuser;
               if (!req_tlast) begin
                  emit      = rel_vld;
                  emit_byte = rel_byte;
                  emit_has  = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            chain_ctl.shift  = 1'b1;
            chain_ctl.rotate = 1'b1;
         end
         ST_PEND: begin
            if (load_ok) begin
               emit      = 1'b1;
               emit_byte = pend_ff;
               emit_has  = 1'b1;
               emit_last = !body_more;
            end
         end
         ST_BODY: begin
            if (load_ok) begin
               emit      = 1'b1;
               emit_last = body_end;
               if (body_more) begin
                  emit_byte        = strip_mode ? tap_byte : pad_val;
                  emit_has         = 1'b1;
                  chain_ctl.shift  = strip_mode;
                  chain_ctl.rotate = strip_mode;
               end
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      fill_in     = fill_ff;
      held_in     = held_ff;
      lo_in       = lo_ff;
      pos_in      = pos_ff;
      keep_in     = keep_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!req_tlast) begin
                  fill_in = fill_nx;
                  held_in = held_new;
               end else begin
                  fill_in     = '0;
                  held_in     = 1'b0;
                  lo_in       = fill_nx;
                  pend_in     = rel_byte;
                  pend_vld_in = rel_vld;
                  if (!strip_mode) begin
                     pos_in  = fill_nx;
                     keep_in = blk_b;
                  end else if (held_new) begin
                     pos_in  = '0;
                     keep_in = (pad_mode == PAD_SPACE || pad_mode == PAD_ZERO) ?
                               fill_nx : blk_b;
                  end else begin
                     pos_in  = '0;
                     keep_in = '0;
                  end
               end
            end
         end
         ST_SCAN: begin
            if (scan_p < {1'b0, blk_b}) begin
               case (pad_mode) inside
                  PAD_LEN: begin
                     if (scan_p == {1'b0, blk_b} - (CNTW+1)'(1)) begin
                        keep_in = (tap_byte > 8'(blk_b)) ? blk_b :
                                  blk_b - CNTW'(tap_byte);
                     end
                  end
                  PAD_ONE: begin
                     if (tap_byte != BYTE_ZERO) begin
                        keep_in = (tap_byte == BYTE_ONE) ? CNTW'(scan_p) : blk_b;
                     end
                  end
                  PAD_SPACE, PAD_ZERO: begin
                     if (tap_byte != pad_ch) begin
                        keep_in = CNTW'(scan_p + (CNTW+1)'(1));
                     end
                  end
                  default: keep_in = keep_ff;
               endcase
            end
            pos_in = scan_end ? lo_ff : pos_ff + CNTW'(1);
         end
         ST_BODY: begin
            if (load_ok && body_more) begin
               pos_in = pos_ff + CNTW'(1);
            end
         end
         default: begin
            pos_in = pos_ff;
         end
      endcase
      if (cfg_clear) begin
         fill_in = '0;
         held_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_has_in   = emit_has;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         held_ff      <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         held_ff      <= held_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      pos_ff      <= pos_in;
      keep_ff     <= keep_in;
      pend_ff     <= pend_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/block_padding_add_strip.sv]
// top level of the block padding adder / stripper
//
//  channel | dir | handshake          | content
//  req     | in  | req_tvalid/tready  | message byte, byte flag, end of message
//  rsp     | out | rsp_tvalid/tready  | output byte, byte flag, final item
//  csr     | in  | csr_we             | pad_mode, block_bytes, strip_mode
//
// one item per cycle inside a message unless rsp stalls; the end item holds req
// for the end sequence; add end: the end item's byte if any, then 1 to block size pads
// strip end: a scan rotating the cell row over the block, then a released byte if any,
// then each kept byte, or one marker item if nothing else goes out
// synchronous reset clears control state; the cell row is not cleared
// rsp stall holds the output register; req waits while the end sequence runs
module block_padding_add_strip
   import bpas_pkg::*;
#(
   parameter int BLOCK_MAX = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tuser,   // has_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // out_byte
   output logic       rsp_tuser,   // out_has_byte
   output logic       rsp_tlast,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [5:0] csr_wdata
);

   localparam int CNTW = $clog2(BLOCK_MAX + 1);
   localparam int IDXW = $clog2(BLOCK_MAX);

   logic [1:0]      pad_mode_ff;
   logic [5:0]      block_bytes_ff;
   logic            strip_mode_ff;
   logic [CNTW-1:0] blk_b;
   logic            cfg_clear;
   logic [7:0]      tap_byte;
   chain_ctl_type   chain_ctl;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_mode_ff    <= PAD_LEN;
         block_bytes_ff <= BLOCK_BYTES_RESET;
         strip_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_PAD_MODE:    pad_mode_ff    <= csr_wdata[1:0];
            REG_BLOCK_BYTES: block_bytes_ff <= csr_wdata;
            REG_STRIP_MODE:  strip_mode_ff  <= csr_wdata[0];
            default:         pad_mode_ff    <= pad_mode_ff;
         endcase
      end
   end

   assign cfg_clear = csr_we &&
                      (csr_index == REG_BLOCK_BYTES || csr_index == REG_STRIP_MODE);

   // block size clamped to 1..BLOCK_MAX
   always_comb begin
      if (block_bytes_ff == '0) begin
         blk_b = CNTW'(1);
      end else if (int'(block_bytes_ff) > BLOCK_MAX) begin
         blk_b = CNTW'(BLOCK_MAX);
      end else begin
         blk_b = CNTW'(block_bytes_ff);
      end
   end

   bpas_chain #(
      .BLOCK_MAX (BLOCK_MAX)
   ) u_chain (
      .clock     (clock),
      .chain_ctl (chain_ctl),
      .head_byte (req_tdata),
      .tap_sel   (IDXW'(blk_b - CNTW'(1))),
      .tap_byte  (tap_byte)
   );

   bpas_ctrl #(
      .BLOCK_MAX (BLOCK_MAX)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .pad_mode   (pad_mode_ff),
      .strip_mode (strip_mode_ff),
      .blk_b      (blk_b),
      .cfg_clear  (cfg_clear),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .tap_byte   (tap_byte),
      .chain_ctl  (chain_ctl),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[verif/bpas_tb_pkg.sv]
// result record and padded-stream predictor for the padding add/strip testbench
`timescale 1ns / 1ps

package bpas_tb_pkg;
   import bpas_pkg::*;

   localparam int BLOCK_MAX = 32;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       last;
   } out_item_type;

   class padded_stream;
      logic [1:0]   pad_mode;
      logic [5:0]   block_bytes;
      logic         strip_mode;
      logic [7:0]   held_block [BLOCK_MAX];
      int           fill_pos;
      bit           block_full;
      out_item_type due_out [$];
      int           error_count;

      function new();
         pad_mode    = PAD_LEN;
         block_bytes = BLOCK_BYTES_RESET;
         strip_mode  = 1'b0;
         fill_pos    = 0;
         block_full  = 1'b0;
         error_count = 0;
         foreach (held_block[i]) held_block[i] = BYTE_ZERO;
      endfunction

      function int waiting();
         return due_out.size();
      endfunction

      function void note_write(logic [1:0] idx, logic [5:0] val);
         case (idx)
            REG_PAD_MODE: pad_mode = val[1:0];
            REG_BLOCK_BYTES: begin
               block_bytes = val;
               fill_pos    = 0;
               block_full  = 1'b0;
            end
            REG_STRIP_MODE: begin
               strip_mode = val[0];
               fill_pos   = 0;
               block_full = 1'b0;
            end
            default: ;
         endcase
      endfunction

      function void push_out(logic [7:0] data, logic has, logic last);
         out_item_type item;
         item.data     = data;
         item.has_byte = has;
         item.last     = last;
         due_out.push_back(item);
      endfunction

      function void take_item(logic [7:0] data, logic has, logic last);
         int         blk;
         int         first;
         int         pad_len;
         int         lo;
         int         keep;
         int         p;
         logic [7:0] fill_char;
         logic [7:0] count;
         blk = (block_bytes == 0) ? 1 :
               (block_bytes > BLOCK_MAX) ? BLOCK_MAX : int'(block_bytes);
         first = due_out.size();
         if (fill_pos >= blk) fill_pos = 0;
         if (has) begin
            if (!strip_mode) begin
               push_out(data, 1'b1, 1'b0);
            end else begin
               if (block_full) push_out(held_block[fill_pos], 1'b1, 1'b0);
               held_block[fill_pos] = data;
            end
            fill_pos++;
            if (fill_pos >= blk) begin
               fill_pos = 0;
               if (strip_mode) block_full = 1'b1;
            end
         end
         if (!last) return;
         if (!strip_mode) begin
            pad_len = blk - fill_pos;
            for (int i = 0; i < pad_len; i++) begin
               case (pad_mode)
                  PAD_LEN:   push_out(8'(pad_len), 1'b1, 1'b0);
                  PAD_ONE:   push_out((i == 0) ? BYTE_ONE : BYTE_ZERO, 1'b1, 1'b0);
                  PAD_SPACE: push_out(BYTE_SPACE, 1'b1, 1'b0);
                  default:   push_out(BYTE_ZERO, 1'b1, 1'b0);
               endcase
            end
         end else if (block_full) begin
            lo = fill_pos;
            if (pad_mode == PAD_LEN) begin
               count = held_block[blk - 1];
               keep  = (count > blk) ? blk : blk - int'(count);
            end else if (pad_mode == PAD_ONE) begin
               p = blk - 1;
               while (p >= lo && held_block[p] == BYTE_ZERO) p--;
               keep = (p >= lo && held_block[p] == BYTE_ONE) ? p : blk;
            end else begin
               fill_char = (pad_mode == PAD_SPACE) ? BYTE_SPACE : BYTE_ZERO;
               p = blk - 1;
               while (p >= lo && held_block[p] == fill_char) p--;
               keep = p + 1;
            end
            for (int i = lo; i < keep; i++) push_out(held_block[i], 1'b1, 1'b0);
         end
         if (due_out.size() > first) due_out[due_out.size() - 1].last = 1'b1;
         else push_out(BYTE_ZERO, 1'b0, 1'b1);
         fill_pos   = 0;
         block_full = 1'b0;
      endfunction

      function void check_item(logic [7:0] data, logic has, logic last);
         out_item_type want;
         if (due_out.size() == 0) begin
            $error("out_byte %02h out_has_byte %0d out_last %0d arrived with none due",
                   data, has, last);
            error_count++;
            return;
         end
         want = due_out.pop_front();
         if (data !== want.data) begin
            $error("out_byte expected %02h actual %02h", want.data, data);
            error_count++;
         end
         if (has !== want.has_byte) begin
            $error("out_has_byte expected %0d actual %0d", want.has_byte, has);
            error_count++;
         end
         if (last !== want.last) begin
            $error("out_last expected %0d actual %0d", want.last, last);
            error_count++;
         end
      endfunction
   endclass

endpackage

[verif/tb_block_padding_add_strip.sv]
// testbench top for the block padding add/strip block
`timescale 1ns / 1ps

module tb_block_padding_add_strip;
   import bpas_pkg::*;
   import bpas_tb_pkg::*;

   localparam int ITEM_TARGET    = 320;
   localparam int PHASE_ITEMS    = 24;
   localparam int DRAIN_CYCLES   = 2 * BLOCK_MAX + 16;
   localparam int HOLD_CYCLES    = 200;
   localparam int WATCHDOG_LIMIT = 2000;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;   // data_byte
   logic       req_tuser  = 1'b0; // has_byte
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;         // out_byte
   logic       rsp_tuser;         // out_has_byte
   logic       rsp_tlast;
   logic       csr_we     = 1'b0;
   logic [1:0] csr_index  = '0;
   logic [5:0] csr_wdata  = '0;

   padded_stream stream_calc;
   int         quiet_cycles = 0;
   int         items_sent   = 0;
   int         tx_idle_pct  = 25;
   int         rx_idle_pct  = 81;
   int         holds_asked  = 0;
   int         holds_done   = 0;
   logic [1:0] cur_pad      = PAD_LEN;
   int         cur_blk      = 16;
   logic       cur_strip    = 1'b0;

   block_padding_add_strip #(.BLOCK_MAX(BLOCK_MAX)) u_top (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (csr_we) stream_calc.note_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) stream_calc.take_item(req_tdata, req_tuser, req_tlast);
         if (rsp_tvalid && rsp_tready) stream_calc.check_item(rsp_tdata, rsp_tuser, rsp_tlast);
         if (csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return BYTE_ZERO;
         1:       return BYTE_SPACE;
         2:       return BYTE_ONE;
         3:       return 8'($urandom_range(1, cur_blk + 1));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic [7:0] data, input logic has, input logic last);
      if (has || last) items_sent++;
      if (items_sent < ITEM_TARGET / 3) begin
         tx_idle_pct = 25;
         rx_idle_pct = 81;
      end else if (items_sent < 2 * ITEM_TARGET / 3) begin
         tx_idle_pct = 81;
         rx_idle_pct = 25;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= has;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (stream_calc.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setting(input logic [1:0] pad, input logic [5:0] blk,
                                input logic strip);
      logic [1:0] reg_idx [4];
      logic [5:0] reg_val [4];
      reg_idx = '{REG_PAD_MODE, REG_BLOCK_BYTES, REG_STRIP_MODE, REG_UNUSED};
      reg_val = '{{4'($urandom), pad}, blk, {5'($urandom), strip}, 6'($urandom)};
      wait_idle();
      for (int k = 0; k < 4; k++) begin
         csr_we    <= 1'b1;
         csr_index <= reg_idx[k];
         csr_wdata <= reg_val[k];
         @(posedge clock);
      end
      csr_we    <= 1'b0;
      cur_pad   = pad;
      cur_strip = strip;
      cur_blk   = (blk == 0) ? 1 : (blk > BLOCK_MAX) ? BLOCK_MAX : int'(blk);
   endtask

   task automatic send_random_message();
      logic [7:0] msg [$];
      int         kind;
      int         blocks;
      int         pad_len;
      bit         end_alone;
      kind = $urandom_range(0, 99);
      if (!cur_strip || kind >= 80) begin
         repeat ($urandom_range(0, 2 * cur_blk + 1)) msg.push_back(pick_byte());
      end else begin
         // well-formed padded message, sometimes damaged
         blocks  = (cur_blk > 8) ? 1 : $urandom_range(1, 3);
         pad_len = $urandom_range(1, cur_blk);
         repeat (blocks * cur_blk - pad_len) msg.push_back(pick_byte());
         for (int i = 0; i < pad_len; i++) begin
            case (cur_pad)
               PAD_LEN:   msg.push_back(8'(pad_len));
               PAD_ONE:   msg.push_back((i == 0) ? BYTE_ONE : BYTE_ZERO);
               PAD_SPACE: msg.push_back(BYTE_SPACE);
               default:   msg.push_back(BYTE_ZERO);
            endcase
         end
         if (kind >= 65) begin
            case ($urandom_range(0, 2))
               0:       msg[$urandom_range(0, msg.size() - 1)] = pick_byte();
               1:       repeat ($urandom_range(1, cur_blk)) msg.push_back(pick_byte());
               default: repeat ($urandom_range(1, cur_blk)) void'(msg.pop_back());
            endcase
         end
      end
      end_alone = (msg.size() == 0) || ($urandom_range(0, 99) < 15);
      foreach (msg[i]) begin
         if ($urandom_range(0, 99) < 5) send_item(pick_byte(), 1'b0, 1'b0);
         send_item(msg[i], 1'b1, !end_alone && (i == msg.size() - 1));
      end
      if (end_alone) send_item(pick_byte(), 1'b0, 1'b1);
   endtask

   initial begin
      int phase_start;
      stream_calc = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // add mode, each pad kind
      apply_setting(PAD_LEN, 6'd4, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b1);
      apply_setting(PAD_ONE, 6'd4, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);
      apply_setting(PAD_SPACE, 6'd4, 1'b0);
      send_item(8'hC3, 1'b0, 1'b0);
      send_item(8'h41, 1'b1, 1'b1);
      apply_setting(PAD_ZERO, 6'd4, 1'b0);
      send_item(8'h20, 1'b1, 1'b1);

      // strip, length byte: normal, count above block, count zero
      apply_setting(PAD_LEN, 6'd2, 1'b1);
      send_item(8'hAA, 1'b1, 1'b0);
      send_item(8'h01, 1'b1, 1'b1);
      send_item(8'hAA, 1'b1, 1'b0);
      send_item(8'h03, 1'b1, 1'b1);
      send_item(8'hAA, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);

      // strip, one-then-zeros: lone final marker, all pad, scan into released part
      apply_setting(PAD_ONE, 6'd2, 1'b1);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b1);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'h01, 1'b1, 1'b1);

      // strip, spaces: trailing partial block, message shorter than a block
      apply_setting(PAD_SPACE, 6'd2, 1'b1);
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'h20, 1'b1, 1'b0);
      send_item(8'h42, 1'b1, 1'b1);
      send_item(8'h41, 1'b1, 1'b1);
      apply_setting(PAD_ZERO, 6'd2, 1'b1);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'h00, 1'b1, 1'b1);

      for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
         case (phase)
            0:       apply_setting(PAD_LEN, 6'd1, 1'b0);
            1:       apply_setting(PAD_ONE, 6'd1, 1'b1);
            2:       apply_setting(PAD_SPACE, 6'd0, 1'b1);
            3:       apply_setting(PAD_ZERO, 6'd32, 1'b0);
            4:       apply_setting(PAD_ONE, 6'd32, 1'b1);
            5:       apply_setting(PAD_LEN, 6'd63, 1'b1);
            default: apply_setting(2'($urandom_range(0, 3)), 6'($urandom_range(1, 8)),
                                   1'($urandom_range(0, 1)));
         endcase
         if (phase == 3) holds_asked++;
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) send_random_message();
      end

      wait_idle();
      if (stream_calc.error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
